[design/jdtp_pkg.sv]
// Package for the job descriptor token parser: token and event codes,
// grammar positions and the beat structs passed between the parser stages.
// No dependencies.
package jdtp_pkg;

  localparam logic [4:0] TK_JOBTYPE     = 5'd0;
  localparam logic [4:0] TK_METRICS     = 5'd1;
  localparam logic [4:0] TK_COMPUTE     = 5'd2;
  localparam logic [4:0] TK_DFS         = 5'd3;
  localparam logic [4:0] TK_BFS         = 5'd4;
  localparam logic [4:0] TK_ALGORITHM   = 5'd5;
  localparam logic [4:0] TK_GRAPH       = 5'd6;
  localparam logic [4:0] TK_INPUT       = 5'd7;
  localparam logic [4:0] TK_NUMVERTICES = 5'd8;
  localparam logic [4:0] TK_EDGES       = 5'd9;
  localparam logic [4:0] TK_LABELS      = 5'd10;
  localparam logic [4:0] TK_NUMBER      = 5'd11;
  localparam logic [4:0] TK_LABEL       = 5'd12;
  localparam logic [4:0] TK_LBRACKET    = 5'd13;
  localparam logic [4:0] TK_RBRACKET    = 5'd14;
  localparam logic [4:0] TK_LBRACE      = 5'd15;
  localparam logic [4:0] TK_RBRACE      = 5'd16;
  localparam logic [4:0] TK_COMMA       = 5'd17;
  localparam logic [4:0] TK_COLON       = 5'd18;
  localparam logic [4:0] TK_EOF         = 5'd22;

  localparam logic [3:0] EV_JOBTYPE     = 4'd0;
  localparam logic [3:0] EV_ALGORITHM   = 4'd1;
  localparam logic [3:0] EV_VERTEXCOUNT = 4'd2;
  localparam logic [3:0] EV_ADDEDGE     = 4'd3;
  localparam logic [3:0] EV_EDGECOUNT   = 4'd4;
  localparam logic [3:0] EV_ADDLABEL    = 4'd5;
  localparam logic [3:0] EV_LABELCOUNT  = 4'd6;
  localparam logic [3:0] EV_ADDINPUT    = 4'd7;
  localparam logic [3:0] EV_INPUTCOUNT  = 4'd8;
  localparam logic [3:0] EV_FINISH      = 4'd9;
  localparam logic [3:0] EV_ERROR       = 4'd10;

  typedef enum logic [5:0] {
    P_JOB_OPEN  = 6'd0,
    P_JOB_KEY   = 6'd1,
    P_JOB_SEP   = 6'd2,
    P_EOF       = 6'd3,
    P_JT_COLON  = 6'd4,
    P_JT_VAL    = 6'd5,
    P_AL_COLON  = 6'd6,
    P_AL_VAL    = 6'd7,
    P_GR_COLON  = 6'd8,
    P_GR_OPEN   = 6'd9,
    P_GR_KEY    = 6'd10,
    P_GR_SEP    = 6'd11,
    P_NV_COLON  = 6'd12,
    P_NV_VAL    = 6'd13,
    P_ED_COLON  = 6'd14,
    P_ED_OPEN   = 6'd15,
    P_ED_FIRST  = 6'd16,
    P_ROW_FIRST = 6'd17,
    P_ROW_NUM   = 6'd18,
    P_ROW_SEP   = 6'd19,
    P_ROW_END   = 6'd20,
    P_ROW_OPEN  = 6'd21,
    P_LB_COLON  = 6'd22,
    P_LB_OPEN   = 6'd23,
    P_LB_FIRST  = 6'd24,
    P_LB_ITEM   = 6'd25,
    P_LB_SEP    = 6'd26,
    P_IN_COLON  = 6'd27,
    P_IN_OPEN   = 6'd28,
    P_IN_FIRST  = 6'd29,
    P_IN_ITEM   = 6'd30,
    P_IN_SEP    = 6'd31
  } pos_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] token_number;
    logic [15:0] string_index;
  } tok_beat_t;

  typedef struct packed {
    logic [3:0]  event_kind;
    logic [15:0] value_first;
    logic [15:0] value_second;
  } evt_beat_t;

endpackage

[design/jdtp_if.sv]
// Valid/ready channel interfaces for lexer tokens and parser events.
// No dependencies.
interface jdtp_tok_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_number;
  logic [15:0] string_index;

  modport source (output valid, token_kind, token_number, string_index, input ready);
  modport sink (input valid, token_kind, token_number, string_index, output ready);
endinterface

interface jdtp_evt_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_kind;
  logic [15:0] value_first;
  logic [15:0] value_second;

  modport source (output valid, event_kind, value_first, value_second, input ready);
  modport sink (input valid, event_kind, value_first, value_second, output ready);
endinterface

[design/jdtp_in_reg.sv]
// Input register of the parser: holds one token beat until the parser core
// consumes it. Depends on jdtp_pkg.
module jdtp_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  jdtp_pkg::tok_beat_t in_beat,
  input  logic                take,
  output logic                hold_valid,
  output jdtp_pkg::tok_beat_t hold_beat
);

  logic                valid_r;
  logic                valid_nxt;
  jdtp_pkg::tok_beat_t beat_r;

  assign in_ready   = !valid_r || take;
  assign hold_valid = valid_r;
  assign hold_beat  = beat_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

endmodule

[design/jdtp_core.sv]
// Grammar state machine and list counters of the parser. Consumes one token
// per advance and produces at most one event. Depends on jdtp_pkg.
module jdtp_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  jdtp_pkg::tok_beat_t tok,
  output logic                emit,
  output jdtp_pkg::evt_beat_t evt
);

  jdtp_pkg::pos_t        pos_r, pos_nxt;
  logic [COUNT_BITS-1:0] edge_total_r, edge_total_nxt;
  logic [COUNT_BITS-1:0] source_row_r, source_row_nxt;
  logic [COUNT_BITS-1:0] label_total_r, label_total_nxt;
  logic [COUNT_BITS-1:0] input_total_r, input_total_nxt;
  logic                  legal;
  logic                  hit;
  logic [31:0]           edge_ext, row_ext, label_ext, input_ext;
  logic [4:0]            t;

  assign t         = tok.token_kind;
  assign edge_ext  = 32'(edge_total_r);
  assign row_ext   = 32'(source_row_r);
  assign label_ext = 32'(label_total_r);
  assign input_ext = 32'(input_total_r);

  always_comb begin
    pos_nxt         = pos_r;
    edge_total_nxt  = edge_total_r;
    source_row_nxt  = source_row_r;
    label_total_nxt = label_total_r;
    input_total_nxt = input_total_r;
    legal           = 1'b1;
    case (pos_r)
      jdtp_pkg::P_JOB_OPEN: begin
        if (t == jdtp_pkg::TK_LBRACE) pos_nxt = jdtp_pkg::P_JOB_KEY;
        else legal = 1'b0;
      end
      jdtp_pkg::P_JOB_KEY: begin
        if (t == jdtp_pkg::TK_JOBTYPE) pos_nxt = jdtp_pkg::P_JT_COLON;
        else if (t == jdtp_pkg::TK_ALGORITHM) pos_nxt = jdtp_pkg::P_AL_COLON;
        else if (t == jdtp_pkg::TK_GRAPH) pos_nxt = jdtp_pkg::P_GR_COLON;
        else if (t == jdtp_pkg::TK_INPUT) pos_nxt = jdtp_pkg::P_IN_COLON;
        else legal = 1'b0;
      end
      jdtp_pkg::P_JOB_SEP: begin
        if (t == jdtp_pkg::TK_RBRACE) pos_nxt = jdtp_pkg::P_EOF;
        else if (t == jdtp_pkg::TK_COMMA) pos_nxt = jdtp_pkg::P_JOB_KEY;
        else legal = 1'b0;
      end
      jdtp_pkg::P_EOF: begin
        if (t == jdtp_pkg::TK_EOF) begin
          pos_nxt         = jdtp_pkg::P_JOB_OPEN;
          edge_total_nxt  = '0;
          source_row_nxt  = '0;
          label_total_nxt = '0;
          input_total_nxt = '0;
        end else legal = 1'b0;
      end
      jdtp_pkg::P_JT_COLON: begin
        if (t == jdtp_pkg::TK_COLON) pos_nxt = jdtp_pkg::P_JT_VAL;
        else legal = 1'b0;
      end
      jdtp_pkg::P_JT_VAL: begin
        if (t inside {jdtp_pkg::TK_METRICS, jdtp_pkg::TK_COMPUTE}) begin
          pos_nxt = jdtp_pkg::P_JOB_SEP;
        end else legal = 1'b0;
      end
      jdtp_pkg::P_AL_COLON: begin
        if (t == jdtp_pkg::TK_COLON) pos_nxt = jdtp_pkg::P_AL_VAL;
        else legal = 1'b0;
      end
      jdtp_pkg::P_AL_VAL: begin
        if (t inside {jdtp_pkg::TK_DFS, jdtp_pkg::TK_BFS}) pos_nxt = jdtp_pkg::P_JOB_SEP;
        else legal = 1'b0;
      end
      jdtp_pkg::P_GR_COLON: begin
        if (t == jdtp_pkg::TK_COLON) pos_nxt = jdtp_pkg::P_GR_OPEN;
        else legal = 1'b0;
      end
      jdtp_pkg::P_GR_OPEN: begin
        if (t == jdtp_pkg::TK_LBRACE) pos_nxt = jdtp_pkg::P_GR_KEY;
        else legal = 1'b0;
      end
      jdtp_pkg::P_GR_KEY: begin
        if (t == jdtp_pkg::TK_NUMVERTICES) pos_nxt = jdtp_pkg::P_NV_COLON;
        else if (t == jdtp_pkg::TK_EDGES) pos_nxt = jdtp_pkg::P_ED_COLON;
        else if (t == jdtp_pkg::TK_LABELS) pos_nxt = jdtp_pkg::P_LB_COLON;
        else legal = 1'b0;
      end
      jdtp_pkg::P_GR_SEP: begin
        if (t == jdtp_pkg::TK_RBRACE) pos_nxt = jdtp_pkg::P_JOB_SEP;
        else if (t == jdtp_pkg::TK_COMMA) pos_nxt = jdtp_pkg::P_GR_KEY;
        else legal = 1'b0;
      end
      jdtp_pkg::P_NV_COLON: begin
        if (t == jdtp_pkg::TK_COLON) pos_nxt = jdtp_pkg::P_NV_VAL;
        else legal = 1'b0;
      end
      jdtp_pkg::P_NV_VAL: begin
        if (t == jdtp_pkg::TK_NUMBER) pos_nxt = jdtp_pkg::P_GR_SEP;
        else legal = 1'b0;
      end
      jdtp_pkg::P_ED_COLON: begin
        if (t == jdtp_pkg::TK_COLON) pos_nxt = jdtp_pkg::P_ED_OPEN;
        else legal = 1'b0;
      end
      jdtp_pkg::P_ED_OPEN: begin
        if (t == jdtp_pkg::TK_LBRACKET) begin
          pos_nxt        = jdtp_pkg::P_ED_FIRST;
          edge_total_nxt = '0;
          source_row_nxt = '0;
        end else legal = 1'b0;
      end
      jdtp_pkg::P_ED_FIRST: begin
        if (t == jdtp_pkg::TK_RBRACKET) pos_nxt = jdtp_pkg::P_GR_SEP;
        else if (t == jdtp_pkg::TK_LBRACKET) pos_nxt = jdtp_pkg::P_ROW_FIRST;
        else legal = 1'b0;
      end
      jdtp_pkg::P_ROW_FIRST, jdtp_pkg::P_ROW_NUM: begin
        if (t == jdtp_pkg::TK_NUMBER) begin
          pos_nxt        = jdtp_pkg::P_ROW_SEP;
          edge_total_nxt = edge_total_r + COUNT_BITS'(1);
        end else if (pos_r == jdtp_pkg::P_ROW_FIRST && t == jdtp_pkg::TK_RBRACKET) begin
          pos_nxt = jdtp_pkg::P_ROW_END;
        end else legal = 1'b0;
      end
      jdtp_pkg::P_ROW_SEP: begin
        if (t == jdtp_pkg::TK_RBRACKET) pos_nxt = jdtp_pkg::P_ROW_END;
        else if (t == jdtp_pkg::TK_COMMA) pos_nxt = jdtp_pkg::P_ROW_NUM;
        else legal = 1'b0;
      end
      jdtp_pkg::P_ROW_END: begin
        if (t == jdtp_pkg::TK_RBRACKET) pos_nxt = jdtp_pkg::P_GR_SEP;
        else if (t == jdtp_pkg::TK_COMMA) begin
          pos_nxt        = jdtp_pkg::P_ROW_OPEN;
          source_row_nxt = source_row_r + COUNT_BITS'(1);
        end else legal = 1'b0;
      end
      jdtp_pkg::P_ROW_OPEN: begin
        if (t == jdtp_pkg::TK_LBRACKET) pos_nxt = jdtp_pkg::P_ROW_FIRST;
        else legal = 1'b0;
      end
      jdtp_pkg::P_LB_COLON: begin
        if (t == jdtp_pkg::TK_COLON) pos_nxt = jdtp_pkg::P_LB_OPEN;
        else legal = 1'b0;
      end
      jdtp_pkg::P_LB_OPEN: begin
        if (t == jdtp_pkg::TK_LBRACKET) begin
          pos_nxt         = jdtp_pkg::P_LB_FIRST;
          label_total_nxt = '0;
        end else legal = 1'b0;
      end
      jdtp_pkg::P_LB_FIRST, jdtp_pkg::P_LB_ITEM: begin
        if (t == jdtp_pkg::TK_LABEL) begin
          pos_nxt         = jdtp_pkg::P_LB_SEP;
          label_total_nxt = label_total_r + COUNT_BITS'(1);
        end else if (pos_r == jdtp_pkg::P_LB_FIRST && t == jdtp_pkg::TK_RBRACKET) begin
          pos_nxt = jdtp_pkg::P_GR_SEP;
        end else legal = 1'b0;
      end
      jdtp_pkg::P_LB_SEP: begin
        if (t == jdtp_pkg::TK_RBRACKET) pos_nxt = jdtp_pkg::P_GR_SEP;
        else if (t == jdtp_pkg::TK_COMMA) pos_nxt = jdtp_pkg::P_LB_ITEM;
        else legal = 1'b0;
      end
      jdtp_pkg::P_IN_COLON: begin
        if (t == jdtp_pkg::TK_COLON) pos_nxt = jdtp_pkg::P_IN_OPEN;
        else legal = 1'b0;
      end
      jdtp_pkg::P_IN_OPEN: begin
        if (t == jdtp_pkg::TK_LBRACKET) begin
          pos_nxt         = jdtp_pkg::P_IN_FIRST;
          input_total_nxt = '0;
        end else legal = 1'b0;
      end
      jdtp_pkg::P_IN_FIRST, jdtp_pkg::P_IN_ITEM: begin
        if (t == jdtp_pkg::TK_NUMBER) begin
          pos_nxt         = jdtp_pkg::P_IN_SEP;
          input_total_nxt = input_total_r + COUNT_BITS'(1);
        end else if (pos_r == jdtp_pkg::P_IN_FIRST && t == jdtp_pkg::TK_RBRACKET) begin
          pos_nxt = jdtp_pkg::P_JOB_SEP;
        end else legal = 1'b0;
      end
      jdtp_pkg::P_IN_SEP: begin
        if (t == jdtp_pkg::TK_RBRACKET) pos_nxt = jdtp_pkg::P_JOB_SEP;
        else if (t == jdtp_pkg::TK_COMMA) pos_nxt = jdtp_pkg::P_IN_ITEM;
        else legal = 1'b0;
      end
      default: legal = 1'b0;
    endcase
    if (!legal) begin
      pos_nxt         = jdtp_pkg::P_JOB_OPEN;
      edge_total_nxt  = '0;
      source_row_nxt  = '0;
      label_total_nxt = '0;
      input_total_nxt = '0;
    end
  end

  always_comb begin
    hit              = 1'b0;
    evt.event_kind   = jdtp_pkg::EV_ERROR;
    evt.value_first  = 16'(t);
    evt.value_second = '0;
    if (legal) begin
      case (pos_r)
        jdtp_pkg::P_EOF: begin
          hit             = 1'b1;
          evt.event_kind  = jdtp_pkg::EV_FINISH;
          evt.value_first = '0;
        end
        jdtp_pkg::P_JT_VAL: begin
          hit            = 1'b1;
          evt.event_kind = jdtp_pkg::EV_JOBTYPE;
        end
        jdtp_pkg::P_AL_VAL: begin
          hit            = 1'b1;
          evt.event_kind = jdtp_pkg::EV_ALGORITHM;
        end
        jdtp_pkg::P_NV_VAL: begin
          hit             = 1'b1;
          evt.event_kind  = jdtp_pkg::EV_VERTEXCOUNT;
          evt.value_first = tok.token_number;
        end
        jdtp_pkg::P_ED_FIRST: begin
          hit             = (t == jdtp_pkg::TK_RBRACKET);
          evt.event_kind  = jdtp_pkg::EV_EDGECOUNT;
          evt.value_first = '0;
        end
        jdtp_pkg::P_ROW_FIRST, jdtp_pkg::P_ROW_NUM: begin
          hit              = (t == jdtp_pkg::TK_NUMBER);
          evt.event_kind   = jdtp_pkg::EV_ADDEDGE;
          evt.value_first  = row_ext[15:0];
          evt.value_second = tok.token_number;
        end
        jdtp_pkg::P_ROW_END: begin
          hit             = (t == jdtp_pkg::TK_RBRACKET);
          evt.event_kind  = jdtp_pkg::EV_EDGECOUNT;
          evt.value_first = edge_ext[15:0];
        end
        jdtp_pkg::P_LB_FIRST, jdtp_pkg::P_LB_ITEM: begin
          hit = 1'b1;
          if (t == jdtp_pkg::TK_LABEL) begin
            evt.event_kind  = jdtp_pkg::EV_ADDLABEL;
            evt.value_first = tok.string_index;
          end else begin
            evt.event_kind  = jdtp_pkg::EV_LABELCOUNT;
            evt.value_first = '0;
          end
        end
        jdtp_pkg::P_LB_SEP: begin
          hit             = (t == jdtp_pkg::TK_RBRACKET);
          evt.event_kind  = jdtp_pkg::EV_LABELCOUNT;
          evt.value_first = label_ext[15:0];
        end
        jdtp_pkg::P_IN_FIRST, jdtp_pkg::P_IN_ITEM: begin
          hit = 1'b1;
          if (t == jdtp_pkg::TK_NUMBER) begin
            evt.event_kind  = jdtp_pkg::EV_ADDINPUT;
            evt.value_first = tok.token_number;
          end else begin
            evt.event_kind  = jdtp_pkg::EV_INPUTCOUNT;
            evt.value_first = '0;
          end
        end
        jdtp_pkg::P_IN_SEP: begin
          hit             = (t == jdtp_pkg::TK_RBRACKET);
          evt.event_kind  = jdtp_pkg::EV_INPUTCOUNT;
          evt.value_first = input_ext[15:0];
        end
        default: hit = 1'b0;
      endcase
    end else begin
      hit = 1'b1;
    end
  end

  assign emit = adv && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= jdtp_pkg::P_JOB_OPEN;
      edge_total_r  <= '0;
      source_row_r  <= '0;
      label_total_r <= '0;
      input_total_r <= '0;
    end else if (adv) begin
      pos_r         <= pos_nxt;
      edge_total_r  <= edge_total_nxt;
      source_row_r  <= source_row_nxt;
      label_total_r <= label_total_nxt;
      input_total_r <= input_total_nxt;
    end
  end

  a_error_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    emit && evt.event_kind == jdtp_pkg::EV_ERROR |=> pos_r == jdtp_pkg::P_JOB_OPEN)
    else $error("Parser did not return to the start after an error event.");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    emit && evt.event_kind == jdtp_pkg::EV_FINISH |=>
      edge_total_r == '0 && label_total_r == '0 && input_total_r == '0)
    else $error("Counters not cleared after a finish event.");

  a_edge_counts: assert property (@(posedge clk) disable iff (!rst_n)
    emit && evt.event_kind == jdtp_pkg::EV_ADDEDGE |=>
      edge_total_r == $past(edge_total_r) + COUNT_BITS'(1))
    else $error("Edge count did not advance with an add-edge event.");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(pos_r) && $stable(source_row_r))
    else $error("Parser state changed without a token.");

endmodule

[design/jdtp_out_reg.sv]
// Output register of the parser: holds one event beat until the receiver
// takes it. Depends on jdtp_pkg.
module jdtp_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  jdtp_pkg::evt_beat_t load_beat,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output jdtp_pkg::evt_beat_t out_beat
);

  logic                valid_r;
  logic                valid_nxt;
  jdtp_pkg::evt_beat_t beat_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_beat  = beat_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= load_beat;
    end
  end

endmodule

[design/job_descriptor_token_parser.sv]
// Job descriptor token parser, top level.
// Depends on jdtp_pkg, jdtp_if, jdtp_in_reg, jdtp_core and jdtp_out_reg.
//
// The lexer delivers one token per beat on in_tok; the parser checks it
// against the job grammar and sends at most one event per token on out_evt.
// Tokens that complete a key value, a list entry, a key's list or the job
// emit an event; keys and other punctuation emit nothing. An unexpected
// token emits an error event carrying the token code and restarts the
// parse, as does a finish. A token is taken into the input register,
// evaluated by the core once the output register can load, and its event
// lands in the output register until the receiver takes it.
// One token is accepted every cycle as long as the output register is
// empty or being drained; the single grammar state update per token sets
// that rate. When the receiver stalls, the event waits in the output
// register, one more token waits in the input register, and in_tok.ready
// then drops. Reset empties both registers, clears all counters and puts
// the parser at the job's opening brace.
// Counters are COUNT_BITS wide; events carry their low 16 bits.
module job_descriptor_token_parser #(
  parameter int COUNT_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  jdtp_tok_if.sink   in_tok,
  jdtp_evt_if.source out_evt
);

  jdtp_pkg::tok_beat_t in_beat;
  jdtp_pkg::tok_beat_t hold_beat;
  jdtp_pkg::evt_beat_t core_evt;
  jdtp_pkg::evt_beat_t out_beat;
  logic                hold_valid;
  logic                can_load;
  logic                adv;
  logic                emit;

  assign in_beat.token_kind   = in_tok.token_kind;
  assign in_beat.token_number = in_tok.token_number;
  assign in_beat.string_index = in_tok.string_index;
  assign adv                  = hold_valid && can_load;

  jdtp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tok.valid),
    .in_ready   (in_tok.ready),
    .in_beat    (in_beat),
    .take       (adv),
    .hold_valid (hold_valid),
    .hold_beat  (hold_beat)
  );

  jdtp_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .tok   (hold_beat),
    .emit  (emit),
    .evt   (core_evt)
  );

  jdtp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (emit),
    .load_beat (core_evt),
    .can_load  (can_load),
    .out_valid (out_evt.valid),
    .out_ready (out_evt.ready),
    .out_beat  (out_beat)
  );

  assign out_evt.event_kind   = out_beat.event_kind;
  assign out_evt.value_first  = out_beat.value_first;
  assign out_evt.value_second = out_beat.value_second;

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// Testbench for job_descriptor_token_parser: a scripted opening, then random jobs
// under three idle patterns, checked against an in-bench grammar tracker.
// Depends on jdtp_pkg, jdtp_if and the parser RTL.
module tb;

  localparam int COUNT_BITS = 16;
  localparam int ITEMS_PER_PHASE = 530;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [4:0] TK_NULL      = 5'd19;
  localparam logic [4:0] TK_TRUE      = 5'd20;
  localparam logic [4:0] TK_INVALID   = 5'd23;
  localparam logic [4:0] TK_UNUSED_LO = 5'd24;
  localparam logic [4:0] TK_UNUSED_HI = 5'd31;

  localparam int SEND_IDLE [3] = '{23, 64, 0};
  localparam int RECV_IDLE [3] = '{64, 23, 0};

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] number;
    logic [15:0] index;
    logic        typed;
    logic [3:0]  want_kind;
    logic [15:0] want_first;
  } script_row_t;

  localparam script_row_t OPENING_SCRIPT [25] = '{
    '{TK_UNUSED_HI, 16'hFFFF, 16'hFFFF, 1'b1, jdtp_pkg::EV_ERROR, {11'd0, TK_UNUSED_HI}},
    '{jdtp_pkg::TK_LBRACE, 16'hFFFF, 16'h0000, 1'b0, '0, '0},
    '{jdtp_pkg::TK_JOBTYPE, 16'h0000, 16'hFFFF, 1'b0, '0, '0},
    '{jdtp_pkg::TK_COLON, 16'h5A5A, 16'hA5A5, 1'b0, '0, '0},
    '{jdtp_pkg::TK_COMPUTE, 16'hA5A5, 16'h5A5A, 1'b1, jdtp_pkg::EV_JOBTYPE,
      {11'd0, jdtp_pkg::TK_COMPUTE}},
    '{jdtp_pkg::TK_COMMA, 16'h0000, 16'h0000, 1'b0, '0, '0},
    '{jdtp_pkg::TK_INPUT, 16'hFFFF, 16'hFFFF, 1'b0, '0, '0},
    '{jdtp_pkg::TK_COLON, 16'h0000, 16'h0000, 1'b0, '0, '0},
    '{jdtp_pkg::TK_LBRACKET, 16'h1234, 16'h4321, 1'b0, '0, '0},
    '{jdtp_pkg::TK_NUMBER, 16'h0000, 16'hFFFF, 1'b1, jdtp_pkg::EV_ADDINPUT, 16'h0000},
    '{jdtp_pkg::TK_RBRACKET, 16'hFFFF, 16'h0000, 1'b1, jdtp_pkg::EV_INPUTCOUNT, 16'd1},
    '{jdtp_pkg::TK_RBRACE, 16'h0000, 16'h0000, 1'b0, '0, '0},
    '{jdtp_pkg::TK_EOF, 16'hFFFF, 16'hFFFF, 1'b1, jdtp_pkg::EV_FINISH, 16'h0000},
    '{jdtp_pkg::TK_EOF, 16'h0000, 16'h0000, 1'b1, jdtp_pkg::EV_ERROR,
      {11'd0, jdtp_pkg::TK_EOF}},
    '{jdtp_pkg::TK_LBRACE, 16'h0000, 16'h0000, 1'b0, '0, '0},
    '{jdtp_pkg::TK_GRAPH, 16'h0000, 16'h0000, 1'b0, '0, '0},
    '{jdtp_pkg::TK_COLON, 16'h0000, 16'h0000, 1'b0, '0, '0},
    '{jdtp_pkg::TK_LBRACE, 16'h0000, 16'h0000, 1'b0, '0, '0},
    '{jdtp_pkg::TK_NUMVERTICES, 16'h0000, 16'h0000, 1'b0, '0, '0},
    '{jdtp_pkg::TK_COLON, 16'h0000, 16'h0000, 1'b0, '0, '0},
    '{jdtp_pkg::TK_NUMBER, 16'hFFFF, 16'h0000, 1'b1, jdtp_pkg::EV_VERTEXCOUNT, 16'hFFFF},
    '{TK_INVALID, 16'h0000, 16'h0000, 1'b1, jdtp_pkg::EV_ERROR, {11'd0, TK_INVALID}},
    '{TK_NULL, 16'hFFFF, 16'hFFFF, 1'b1, jdtp_pkg::EV_ERROR, {11'd0, TK_NULL}},
    '{TK_UNUSED_LO, 16'h0000, 16'hFFFF, 1'b1, jdtp_pkg::EV_ERROR, {11'd0, TK_UNUSED_LO}},
    '{TK_TRUE, 16'hFFFF, 16'h0000, 1'b1, jdtp_pkg::EV_ERROR, {11'd0, TK_TRUE}}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  jdtp_tok_if tok_ch ();
  jdtp_evt_if evt_ch ();

  job_descriptor_token_parser #(.COUNT_BITS(COUNT_BITS)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tok  (tok_ch),
    .out_evt (evt_ch)
  );

  jdtp_pkg::pos_t parse_pos;
  logic [COUNT_BITS-1:0] edge_total;
  logic [COUNT_BITS-1:0] source_row;
  logic [COUNT_BITS-1:0] label_total;
  logic [COUNT_BITS-1:0] input_total;

  jdtp_pkg::evt_beat_t expected_events [$];
  jdtp_pkg::tok_beat_t job_q [$];

  logic                beat_typed;
  jdtp_pkg::evt_beat_t beat_want;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_left = 0;
  int        cycle_count = 0;
  int        tokens_accepted = 0;
  int        events_seen = 0;
  int        error_events = 0;
  int        mismatch_count = 0;
  bit [15:0] kinds_seen = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic jdtp_pkg::evt_beat_t make_event(input logic [3:0] kind,
                                                     input logic [15:0] first,
                                                     input logic [15:0] second);
    return {kind, first, second};
  endfunction

  function automatic void restart_parse();
    parse_pos = jdtp_pkg::P_JOB_OPEN;
    edge_total = '0;
    source_row = '0;
    label_total = '0;
    input_total = '0;
  endfunction

  function automatic bit advance_on(input logic [4:0] kind, input logic [4:0] want,
                                    input jdtp_pkg::pos_t next);
    if (kind != want) return 1'b0;
    parse_pos = next;
    return 1'b1;
  endfunction

  // Returns 1 when the token produces an event, which is placed in ev.
  function automatic bit parse_token(input jdtp_pkg::tok_beat_t tk,
                                     output jdtp_pkg::evt_beat_t ev);
    logic [4:0] kind;
    bit bad;
    bit emitted;
    kind = tk.token_kind;
    bad = 1'b0;
    emitted = 1'b0;
    ev = '0;
    case (parse_pos)
      jdtp_pkg::P_JOB_OPEN: begin
        bad = !advance_on(kind, jdtp_pkg::TK_LBRACE, jdtp_pkg::P_JOB_KEY);
      end
      jdtp_pkg::P_JOB_KEY: begin
        case (kind)
          jdtp_pkg::TK_JOBTYPE:   parse_pos = jdtp_pkg::P_JT_COLON;
          jdtp_pkg::TK_ALGORITHM: parse_pos = jdtp_pkg::P_AL_COLON;
          jdtp_pkg::TK_GRAPH:     parse_pos = jdtp_pkg::P_GR_COLON;
          jdtp_pkg::TK_INPUT:     parse_pos = jdtp_pkg::P_IN_COLON;
          default:                bad = 1'b1;
        endcase
      end
      jdtp_pkg::P_JOB_SEP: begin
        if (kind == jdtp_pkg::TK_RBRACE) parse_pos = jdtp_pkg::P_EOF;
        else bad = !advance_on(kind, jdtp_pkg::TK_COMMA, jdtp_pkg::P_JOB_KEY);
      end
      jdtp_pkg::P_EOF: begin
        if (kind == jdtp_pkg::TK_EOF) begin
          restart_parse();
          ev = make_event(jdtp_pkg::EV_FINISH, 16'd0, 16'd0);
          emitted = 1'b1;
        end else bad = 1'b1;
      end
      jdtp_pkg::P_JT_COLON: begin
        bad = !advance_on(kind, jdtp_pkg::TK_COLON, jdtp_pkg::P_JT_VAL);
      end
      jdtp_pkg::P_JT_VAL: begin
        if (kind == jdtp_pkg::TK_METRICS || kind == jdtp_pkg::TK_COMPUTE) begin
          parse_pos = jdtp_pkg::P_JOB_SEP;
          ev = make_event(jdtp_pkg::EV_JOBTYPE, {11'd0, kind}, 16'd0);
          emitted = 1'b1;
        end else bad = 1'b1;
      end
      jdtp_pkg::P_AL_COLON: begin
        bad = !advance_on(kind, jdtp_pkg::TK_COLON, jdtp_pkg::P_AL_VAL);
      end
      jdtp_pkg::P_AL_VAL: begin
        if (kind == jdtp_pkg::TK_DFS || kind == jdtp_pkg::TK_BFS) begin
          parse_pos = jdtp_pkg::P_JOB_SEP;
          ev = make_event(jdtp_pkg::EV_ALGORITHM, {11'd0, kind}, 16'd0);
          emitted = 1'b1;
        end else bad = 1'b1;
      end
      jdtp_pkg::P_GR_COLON: begin
        bad = !advance_on(kind, jdtp_pkg::TK_COLON, jdtp_pkg::P_GR_OPEN);
      end
      jdtp_pkg::P_GR_OPEN: begin
        bad = !advance_on(kind, jdtp_pkg::TK_LBRACE, jdtp_pkg::P_GR_KEY);
      end
      jdtp_pkg::P_GR_KEY: begin
        case (kind)
          jdtp_pkg::TK_NUMVERTICES: parse_pos = jdtp_pkg::P_NV_COLON;
          jdtp_pkg::TK_EDGES:       parse_pos = jdtp_pkg::P_ED_COLON;
          jdtp_pkg::TK_LABELS:      parse_pos = jdtp_pkg::P_LB_COLON;
          default:                  bad = 1'b1;
        endcase
      end
      jdtp_pkg::P_GR_SEP: begin
        if (kind == jdtp_pkg::TK_RBRACE) parse_pos = jdtp_pkg::P_JOB_SEP;
        else bad = !advance_on(kind, jdtp_pkg::TK_COMMA, jdtp_pkg::P_GR_KEY);
      end
      jdtp_pkg::P_NV_COLON: begin
        bad = !advance_on(kind, jdtp_pkg::TK_COLON, jdtp_pkg::P_NV_VAL);
      end
      jdtp_pkg::P_NV_VAL: begin
        if (kind == jdtp_pkg::TK_NUMBER) begin
          parse_pos = jdtp_pkg::P_GR_SEP;
          ev = make_event(jdtp_pkg::EV_VERTEXCOUNT, tk.token_number, 16'd0);
          emitted = 1'b1;
        end else bad = 1'b1;
      end
      jdtp_pkg::P_ED_COLON: begin
        bad = !advance_on(kind, jdtp_pkg::TK_COLON, jdtp_pkg::P_ED_OPEN);
      end
      jdtp_pkg::P_ED_OPEN: begin
        if (kind == jdtp_pkg::TK_LBRACKET) begin
          edge_total = '0;
          source_row = '0;
          parse_pos = jdtp_pkg::P_ED_FIRST;
        end else bad = 1'b1;
      end
      jdtp_pkg::P_ED_FIRST: begin
        if (kind == jdtp_pkg::TK_RBRACKET) begin
          parse_pos = jdtp_pkg::P_GR_SEP;
          ev = make_event(jdtp_pkg::EV_EDGECOUNT, 16'd0, 16'd0);
          emitted = 1'b1;
        end else bad = !advance_on(kind, jdtp_pkg::TK_LBRACKET, jdtp_pkg::P_ROW_FIRST);
      end
      jdtp_pkg::P_ROW_FIRST, jdtp_pkg::P_ROW_NUM: begin
        if (kind == jdtp_pkg::TK_NUMBER) begin
          edge_total = edge_total + 1'b1;
          parse_pos = jdtp_pkg::P_ROW_SEP;
          ev = make_event(jdtp_pkg::EV_ADDEDGE, 16'(source_row), tk.token_number);
          emitted = 1'b1;
        end else if (parse_pos == jdtp_pkg::P_ROW_FIRST && kind == jdtp_pkg::TK_RBRACKET) begin
          parse_pos = jdtp_pkg::P_ROW_END;
        end else bad = 1'b1;
      end
      jdtp_pkg::P_ROW_SEP: begin
        if (kind == jdtp_pkg::TK_RBRACKET) parse_pos = jdtp_pkg::P_ROW_END;
        else bad = !advance_on(kind, jdtp_pkg::TK_COMMA, jdtp_pkg::P_ROW_NUM);
      end
      jdtp_pkg::P_ROW_END: begin
        if (kind == jdtp_pkg::TK_RBRACKET) begin
          parse_pos = jdtp_pkg::P_GR_SEP;
          ev = make_event(jdtp_pkg::EV_EDGECOUNT, 16'(edge_total), 16'd0);
          emitted = 1'b1;
        end else if (kind == jdtp_pkg::TK_COMMA) begin
          source_row = source_row + 1'b1;
          parse_pos = jdtp_pkg::P_ROW_OPEN;
        end else bad = 1'b1;
      end
      jdtp_pkg::P_ROW_OPEN: begin
        bad = !advance_on(kind, jdtp_pkg::TK_LBRACKET, jdtp_pkg::P_ROW_FIRST);
      end
      jdtp_pkg::P_LB_COLON: begin
        bad = !advance_on(kind, jdtp_pkg::TK_COLON, jdtp_pkg::P_LB_OPEN);
      end
      jdtp_pkg::P_LB_OPEN: begin
        if (kind == jdtp_pkg::TK_LBRACKET) begin
          label_total = '0;
          parse_pos = jdtp_pkg::P_LB_FIRST;
        end else bad = 1'b1;
      end
      jdtp_pkg::P_LB_FIRST, jdtp_pkg::P_LB_ITEM: begin
        if (kind == jdtp_pkg::TK_LABEL) begin
          label_total = label_total + 1'b1;
          parse_pos = jdtp_pkg::P_LB_SEP;
          ev = make_event(jdtp_pkg::EV_ADDLABEL, tk.string_index, 16'd0);
          emitted = 1'b1;
        end else if (parse_pos == jdtp_pkg::P_LB_FIRST && kind == jdtp_pkg::TK_RBRACKET) begin
          parse_pos = jdtp_pkg::P_GR_SEP;
          ev = make_event(jdtp_pkg::EV_LABELCOUNT, 16'd0, 16'd0);
          emitted = 1'b1;
        end else bad = 1'b1;
      end
      jdtp_pkg::P_LB_SEP: begin
        if (kind == jdtp_pkg::TK_RBRACKET) begin
          parse_pos = jdtp_pkg::P_GR_SEP;
          ev = make_event(jdtp_pkg::EV_LABELCOUNT, 16'(label_total), 16'd0);
          emitted = 1'b1;
        end else bad = !advance_on(kind, jdtp_pkg::TK_COMMA, jdtp_pkg::P_LB_ITEM);
      end
      jdtp_pkg::P_IN_COLON: begin
        bad = !advance_on(kind, jdtp_pkg::TK_COLON, jdtp_pkg::P_IN_OPEN);
      end
      jdtp_pkg::P_IN_OPEN: begin
        if (kind == jdtp_pkg::TK_LBRACKET) begin
          input_total = '0;
          parse_pos = jdtp_pkg::P_IN_FIRST;
        end else bad = 1'b1;
      end
      jdtp_pkg::P_IN_FIRST, jdtp_pkg::P_IN_ITEM: begin
        if (kind == jdtp_pkg::TK_NUMBER) begin
          input_total = input_total + 1'b1;
          parse_pos = jdtp_pkg::P_IN_SEP;
          ev = make_event(jdtp_pkg::EV_ADDINPUT, tk.token_number, 16'd0);
          emitted = 1'b1;
        end else if (parse_pos == jdtp_pkg::P_IN_FIRST && kind == jdtp_pkg::TK_RBRACKET) begin
          parse_pos = jdtp_pkg::P_JOB_SEP;
          ev = make_event(jdtp_pkg::EV_INPUTCOUNT, 16'd0, 16'd0);
          emitted = 1'b1;
        end else bad = 1'b1;
      end
      jdtp_pkg::P_IN_SEP: begin
        if (kind == jdtp_pkg::TK_RBRACKET) begin
          parse_pos = jdtp_pkg::P_JOB_SEP;
          ev = make_event(jdtp_pkg::EV_INPUTCOUNT, 16'(input_total), 16'd0);
          emitted = 1'b1;
        end else bad = !advance_on(kind, jdtp_pkg::TK_COMMA, jdtp_pkg::P_IN_ITEM);
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      restart_parse();
      ev = make_event(jdtp_pkg::EV_ERROR, {11'd0, kind}, 16'd0);
      emitted = 1'b1;
    end
    return emitted;
  endfunction

  function automatic logic [15:0] rand_word();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void push_tok(input logic [4:0] kind);
    job_q.push_back({kind, rand_word(), rand_word()});
  endfunction

  function automatic void push_list(input logic [4:0] kind, input int n);
    push_tok(jdtp_pkg::TK_LBRACKET);
    for (int i = 0; i < n; i++) begin
      if (i > 0) push_tok(jdtp_pkg::TK_COMMA);
      push_tok(kind);
    end
    push_tok(jdtp_pkg::TK_RBRACKET);
  endfunction

  function automatic void build_job();
    int nkeys;
    int ngraph;
    int nrows;
    nkeys = $urandom_range(5, 1);
    push_tok(jdtp_pkg::TK_LBRACE);
    for (int k = 0; k < nkeys; k++) begin
      if (k > 0) push_tok(jdtp_pkg::TK_COMMA);
      case ($urandom_range(3))
        0: begin
          push_tok(jdtp_pkg::TK_JOBTYPE);
          push_tok(jdtp_pkg::TK_COLON);
          push_tok($urandom_range(1) ? jdtp_pkg::TK_METRICS : jdtp_pkg::TK_COMPUTE);
        end
        1: begin
          push_tok(jdtp_pkg::TK_ALGORITHM);
          push_tok(jdtp_pkg::TK_COLON);
          push_tok($urandom_range(1) ? jdtp_pkg::TK_DFS : jdtp_pkg::TK_BFS);
        end
        2: begin
          push_tok(jdtp_pkg::TK_GRAPH);
          push_tok(jdtp_pkg::TK_COLON);
          push_tok(jdtp_pkg::TK_LBRACE);
          ngraph = $urandom_range(3, 1);
          for (int g = 0; g < ngraph; g++) begin
            if (g > 0) push_tok(jdtp_pkg::TK_COMMA);
            case ($urandom_range(2))
              0: begin
                push_tok(jdtp_pkg::TK_NUMVERTICES);
                push_tok(jdtp_pkg::TK_COLON);
                push_tok(jdtp_pkg::TK_NUMBER);
              end
              1: begin
                push_tok(jdtp_pkg::TK_EDGES);
                push_tok(jdtp_pkg::TK_COLON);
                push_tok(jdtp_pkg::TK_LBRACKET);
                nrows = $urandom_range(3);
                for (int r = 0; r < nrows; r++) begin
                  if (r > 0) push_tok(jdtp_pkg::TK_COMMA);
                  push_list(jdtp_pkg::TK_NUMBER, $urandom_range(3));
                end
                push_tok(jdtp_pkg::TK_RBRACKET);
              end
              default: begin
                push_tok(jdtp_pkg::TK_LABELS);
                push_tok(jdtp_pkg::TK_COLON);
                push_list(jdtp_pkg::TK_LABEL, $urandom_range(4));
              end
            endcase
          end
          push_tok(jdtp_pkg::TK_RBRACE);
        end
        default: begin
          push_tok(jdtp_pkg::TK_INPUT);
          push_tok(jdtp_pkg::TK_COLON);
          push_list(jdtp_pkg::TK_NUMBER, $urandom_range(4));
        end
      endcase
    end
    push_tok(jdtp_pkg::TK_RBRACE);
    push_tok(jdtp_pkg::TK_EOF);
  endfunction

  task automatic report_mismatch(input string detail);
    mismatch_count++;
    $display("[cycle %0d] mismatch: %s", cycle_count, detail);
  endtask

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_token(input jdtp_pkg::tok_beat_t tk, input logic typed,
                            input jdtp_pkg::evt_beat_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      tok_ch.valid = 1'b0;
      @(negedge clk);
    end
    tok_ch.valid = 1'b1;
    tok_ch.token_kind = tk.token_kind;
    tok_ch.token_number = tk.token_number;
    tok_ch.string_index = tk.string_index;
    beat_typed = typed;
    beat_want = want;
    do @(posedge clk); while (!tok_ch.ready);
    @(negedge clk);
    tok_ch.valid = 1'b0;
  endtask

  // Mostly well-formed jobs; some are preceded by a stray token or cut short
  // by a random token at a random point.
  task automatic run_jobs(input int quota);
    int start;
    int cut;
    start = tokens_accepted;
    while (tokens_accepted - start < quota) begin
      job_q.delete();
      if ($urandom_range(9) == 0) push_tok(5'($urandom_range(31)));
      build_job();
      if ($urandom_range(5) == 0) begin
        cut = $urandom_range(job_q.size() - 1);
        job_q[cut].token_kind = 5'($urandom_range(31));
        while (job_q.size() > cut + 1) void'(job_q.pop_back());
      end
      foreach (job_q[i]) send_token(job_q[i], 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin : watch_tokens
    jdtp_pkg::tok_beat_t tk;
    jdtp_pkg::evt_beat_t ev;
    bit emitted;
    if (rst_n && tok_ch.valid && tok_ch.ready) begin
      tokens_accepted++;
      tk = {tok_ch.token_kind, tok_ch.token_number, tok_ch.string_index};
      emitted = parse_token(tk, ev);
      if (beat_typed) expected_events.push_back(beat_want);
      else if (emitted) expected_events.push_back(ev);
    end
  end

  always @(posedge clk) begin : watch_events
    jdtp_pkg::evt_beat_t want;
    if (rst_n && evt_ch.valid && evt_ch.ready) begin
      events_seen++;
      kinds_seen[evt_ch.event_kind] = 1'b1;
      if (evt_ch.event_kind == jdtp_pkg::EV_ERROR) error_events++;
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event kind %0d, values %h/%h",
                                  evt_ch.event_kind, evt_ch.value_first, evt_ch.value_second));
      end else begin
        want = expected_events.pop_front();
        if (evt_ch.event_kind !== want.event_kind)
          report_mismatch($sformatf("event_kind %0d, expected %0d",
                                    evt_ch.event_kind, want.event_kind));
        if (evt_ch.value_first !== want.value_first)
          report_mismatch($sformatf("value_first %h, expected %h (kind %0d)",
                                    evt_ch.value_first, want.value_first, want.event_kind));
        if (evt_ch.value_second !== want.value_second)
          report_mismatch($sformatf("value_second %h, expected %h (kind %0d)",
                                    evt_ch.value_second, want.value_second, want.event_kind));
      end
    end
  end

  initial begin
    evt_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        evt_ch.ready = 1'b0;
        hold_left--;
      end else begin
        evt_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d events pending",
               cycle_count, expected_events.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    tok_ch.valid = 1'b0;
    tok_ch.token_kind = '0;
    tok_ch.token_number = '0;
    tok_ch.string_index = '0;
    beat_typed = 1'b0;
    beat_want = '0;
    send_idle_pct = SEND_IDLE[0];
    recv_idle_pct = RECV_IDLE[0];
    restart_parse();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < $size(OPENING_SCRIPT); i++) begin
      send_token({OPENING_SCRIPT[i].kind, OPENING_SCRIPT[i].number, OPENING_SCRIPT[i].index},
                 OPENING_SCRIPT[i].typed,
                 {OPENING_SCRIPT[i].want_kind, OPENING_SCRIPT[i].want_first, 16'd0});
    end
    beat_typed = 1'b0;

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = SEND_IDLE[ph];
      recv_idle_pct = RECV_IDLE[ph];
      // In the last phase the receiver stalls for a long stretch while tokens keep coming.
      if (ph == 2) begin
        @(posedge clk);
        hold_left = LONG_HOLD;
        @(negedge clk);
      end
      run_jobs(ITEMS_PER_PHASE);
      while (expected_events.size() != 0) @(negedge clk);
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Run covered %0d tokens and %0d events (%0d error events, %0d of 11 event kinds).",
             tokens_accepted, events_seen, error_events, $countones(kinds_seen));
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches found", mismatch_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[job_descriptor_token_parser.f]
design/jdtp_pkg.sv
design/jdtp_if.sv
design/jdtp_in_reg.sv
design/jdtp_core.sv
design/jdtp_out_reg.sv
design/job_descriptor_token_parser.sv
sim/tb.sv
